/* rtl/cone_beam_ray_voxel_indexer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cone-beam ray voxel indexer
// Short forms for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CONE_BEAM_RAY_VOXEL_INDEXER_DEFINES_SVH
`define CONE_BEAM_RAY_VOXEL_INDEXER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBRVI_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen outside reset.
`define CBRVI_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/cbrvi_pkg.sv */
// ----------------------------------------------------------------------------
// Cone-beam ray voxel indexer package
// Beat types, register indexes and fixed-point constants of the indexer.
// ----------------------------------------------------------------------------
package cbrvi_pkg;

  typedef struct packed {
    logic [8:0] slice_index;
    logic [8:0] column_index;
    logic [8:0] plane_number;
  } item_t;

  typedef struct packed {
    logic [26:0] voxel_index;
    logic [17:0] ray_number;
  } result_t;

  typedef enum logic [2:0] {
    CFG_VIEW_SIN,
    CFG_VIEW_COS,
    CFG_SOURCE_RADIUS,
    CFG_DETECTOR_OFFSET,
    CFG_DETECTOR_PITCH,
    CFG_SOURCE_Z,
    CFG_VOLUME_HALF,
    CFG_VOXEL_PITCH
  } cfg_index_t;

  // Side data that rides along with the ratio division.
  typedef struct packed {
    logic               neg;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] z2;
    logic signed [31:0] yp;
    logic        [17:0] ray;
  } ray_side_t;

  localparam int FRAC = 16;
  localparam int R_QB = 31;
  localparam logic [31:0] R_MAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] R_MIN = 32'sh8000_0000;

  localparam logic signed [17:0] RST_VIEW_SIN        = 18'sd0;
  localparam logic signed [17:0] RST_VIEW_COS        = 18'sd65536;
  localparam logic        [30:0] RST_SOURCE_RADIUS   = 31'd10920985;
  localparam logic        [30:0] RST_DETECTOR_OFFSET = 31'd70222872;
  localparam logic        [30:0] RST_DETECTOR_PITCH  = 31'd52429;
  localparam logic signed [31:0] RST_SOURCE_Z        = 32'sd3383624;
  localparam logic        [30:0] RST_VOLUME_HALF     = 31'd2649620;
  localparam logic        [30:0] RST_VOXEL_PITCH     = 31'd10350;

endpackage

/* rtl/cbrvi_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned, one quotient bit per stage, several lanes sharing one divisor.
// ----------------------------------------------------------------------------
module cbrvi_div #(
  parameter int NW    = 49,
  parameter int DW    = 33,
  parameter int QB    = 31,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NW-1:0]    num,
  input  logic [DW-1:0]               den,
  input  logic [SW-1:0]               side,
  output logic                        out_valid,
  output logic [LANES-1:0][QB-1:0]    quo,
  output logic [LANES-1:0]            ovf,
  output logic [LANES-1:0]            rem_nz,
  output logic [SW-1:0]               out_side
);

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic [QB:0]                 vld;
  logic [LANES-1:0][NW-1:0]    rem     [QB+1];
  logic [LANES-1:0][QB-1:0]    quo_r   [QB+1];
  logic [LANES-1:0]            ov      [QB+1];
  logic [DW-1:0]               dv      [QB+1];
  logic [SW-1:0]               sd      [QB+1];
  logic [LANES-1:0]            take    [QB];
  logic [LANES-1:0][NW-1:0]    rem_sub [QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QB-1:0], in_valid};
    end
  end

  // Each stage tries the divisor shifted to its own quotient bit.
  always_comb begin
    for (int s = 0; s < QB; s++) begin
      for (int ln = 0; ln < LANES; ln++) begin
        take[s][ln]    = CW'(rem[s][ln]) >= (CW'(dv[s]) << (QB - 1 - s));
        rem_sub[s][ln] = rem[s][ln] - NW'(CW'(dv[s]) << (QB - 1 - s));
      end
    end
  end

  always_ff @(posedge clk) begin
    rem[0]   <= num;
    quo_r[0] <= '0;
    dv[0]    <= den;
    sd[0]    <= side;
    for (int ln = 0; ln < LANES; ln++) begin
      ov[0][ln] <= CW'(num[ln]) >= (CW'(den) << QB);
    end
    for (int s = 0; s < QB; s++) begin
      dv[s+1] <= dv[s];
      sd[s+1] <= sd[s];
      ov[s+1] <= ov[s];
      for (int ln = 0; ln < LANES; ln++) begin
        rem[s+1][ln]   <= take[s][ln] ? rem_sub[s][ln] : rem[s][ln];
        quo_r[s+1][ln] <= quo_r[s][ln] | (QB'(take[s][ln]) << (QB - 1 - s));
      end
    end
  end

  always_comb begin
    for (int ln = 0; ln < LANES; ln++) begin
      rem_nz[ln] = |rem[QB][ln];
    end
  end

  assign out_valid = vld[QB];
  assign quo       = quo_r[QB];
  assign ovf       = ov[QB];
  assign out_side  = sd[QB];

endmodule

/* rtl/cone_beam_ray_voxel_indexer.sv */
// ----------------------------------------------------------------------------
// Cone-beam ray voxel indexer
// Intersects a source-to-detector-cell ray with one voxel plane, gives address.
// ----------------------------------------------------------------------------
// How the block is used.
// An item (detector slice, detector column, voxel plane) is taken on the item
// port at a rising edge where start is high and busy is low. busy is high only
// while rst is asserted, so one beat may be offered in every cycle.
// Through stages A to F, the ratio divider, stages G to J, the voxel divider and
// stage K a hit goes on to the result port, with done high for exactly one cycle.
// Items that miss the volume, or whose ray runs parallel to the voxel plane, give
// no beat at all; results keep the order of the items.
// The pipeline holds the two restoring dividers, 32 stages for the Q16.16 ray
// ratio and log2(NPIX) + 1 stages for the three voxel coordinates, plus eleven
// stages of multiply, saturate and compare around them.
// Throughput is one item per cycle. The receiver cannot stall the block, and
// the pipeline never holds a beat back.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; registers should only be written while no item is in flight.
// Synchronous reset restores the default geometry and empties the pipeline.
// ----------------------------------------------------------------------------
`include "cone_beam_ray_voxel_indexer_defines.svh"

module cone_beam_ray_voxel_indexer #(
  parameter int NPIX   = 512,
  parameter int NDET   = 512,
  parameter int NSLICE = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  cbrvi_pkg::item_t       item,
  output logic                   done,
  output cbrvi_pkg::result_t     result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  cbrvi_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]            cfg_data
);

  // Width of the detector offset factor 2*(N/2) - 1 - 2*index.
  localparam int NMAX    = (NDET > NSLICE) ? NDET : NSLICE;
  localparam int FW0     = $clog2(NMAX) + 1;
  localparam int FW      = ((FW0 > 11) ? FW0 : 11) + 1;
  localparam int PW      = FW + 32;
  localparam int PCW     = PW + 18;
  localparam int MW      = $clog2(NPIX);
  localparam int IW      = 3 * MW;
  localparam int SIDE_W  = $bits(cbrvi_pkg::ray_side_t);
  localparam int LATENCY = 6 + (cbrvi_pkg::R_QB + 1) + 4 + (MW + 1) + 1;
  localparam logic signed [FW-1:0] F1_BASE = FW'(2 * (NDET / 2) - 1);
  localparam logic signed [FW-1:0] F3_BASE = FW'(2 * (NSLICE / 2) - 1);
  localparam logic [MW-1:0] M_MAX = MW'(NPIX - 1);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  function automatic logic [MW-1:0] clamp_m(input logic [MW-1:0] q, input logic o);
    if (o || (q > M_MAX)) begin
      return M_MAX;
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. The channel never pushes back.
  // --------------------------------------------------------------------------
  logic signed [17:0] view_sin;
  logic signed [17:0] view_cos;
  logic        [30:0] source_radius;
  logic        [30:0] detector_offset;
  logic        [30:0] detector_pitch;
  logic signed [31:0] source_z;
  logic        [30:0] volume_half;
  logic        [30:0] voxel_pitch;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_sin        <= cbrvi_pkg::RST_VIEW_SIN;
      view_cos        <= cbrvi_pkg::RST_VIEW_COS;
      source_radius   <= cbrvi_pkg::RST_SOURCE_RADIUS;
      detector_offset <= cbrvi_pkg::RST_DETECTOR_OFFSET;
      detector_pitch  <= cbrvi_pkg::RST_DETECTOR_PITCH;
      source_z        <= cbrvi_pkg::RST_SOURCE_Z;
      volume_half     <= cbrvi_pkg::RST_VOLUME_HALF;
      voxel_pitch     <= cbrvi_pkg::RST_VOXEL_PITCH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbrvi_pkg::CFG_VIEW_SIN:        view_sin        <= cfg_data[17:0];
        cbrvi_pkg::CFG_VIEW_COS:        view_cos        <= cfg_data[17:0];
        cbrvi_pkg::CFG_SOURCE_RADIUS:   source_radius   <= cfg_data[30:0];
        cbrvi_pkg::CFG_DETECTOR_OFFSET: detector_offset <= cfg_data[30:0];
        cbrvi_pkg::CFG_DETECTOR_PITCH:  detector_pitch  <= cfg_data[30:0];
        cbrvi_pkg::CFG_SOURCE_Z:        source_z        <= cfg_data;
        cbrvi_pkg::CFG_VOLUME_HALF:     volume_half     <= cfg_data[30:0];
        cbrvi_pkg::CFG_VOXEL_PITCH:     voxel_pitch     <= cfg_data[30:0];
      endcase
    end
  end

  // A zero voxel pitch is taken as one LSB so the divisions stay defined.
  logic        [30:0] vp;
  logic signed [31:0] hs;
  assign vp = (voxel_pitch == '0) ? 31'd1 : voxel_pitch;
  assign hs = $signed({1'b0, volume_half});

  // --------------------------------------------------------------------------
  // Stage A: first products. The detector factors are small signed integers.
  // --------------------------------------------------------------------------
  logic signed [FW-1:0] f1, f3;
  assign f1 = F1_BASE - $signed(FW'({item.column_index, 1'b0}));
  assign f3 = F3_BASE - $signed(FW'({item.slice_index, 1'b0}));

  logic                a_vld;
  logic signed [49:0]  a_rsin, a_rcos;
  logic signed [PW-1:0] a_f1d, a_f3d;
  logic        [39:0]  a_lv;
  logic        [17:0]  a_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_rsin <= $signed({1'b0, source_radius}) * view_sin;
    a_rcos <= $signed({1'b0, source_radius}) * view_cos;
    a_f1d  <= f1 * $signed({1'b0, detector_pitch});
    a_f3d  <= f3 * $signed({1'b0, detector_pitch});
    a_lv   <= item.plane_number * vp;
    a_ray  <= 18'(32'(item.slice_index) * 32'(NDET) + 32'(item.column_index));
  end

  // --------------------------------------------------------------------------
  // Stage B: source position, cell offsets, axial cell position and plane y.
  // --------------------------------------------------------------------------
  logic                b_vld;
  logic signed [31:0]  b_x1, b_y1, b_z2, b_yp;
  logic signed [PW-1:0] b_p1;
  logic        [17:0]  b_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_x1  <= sat32(66'(a_rsin >>> cbrvi_pkg::FRAC));
    b_y1  <= sat32(-66'(a_rcos >>> cbrvi_pkg::FRAC));
    b_p1  <= a_f1d >>> 1;
    b_z2  <= sat32(66'(source_z) + 66'(a_f3d >>> 1));
    b_yp  <= sat32(66'($signed({1'b0, a_lv})) - 66'(hs));
    b_ray <= a_ray;
  end

  // --------------------------------------------------------------------------
  // Stage C: rotation products for the detector cell.
  // --------------------------------------------------------------------------
  logic                 c_vld;
  logic signed [PCW-1:0] c_pc, c_qs;
  logic signed [49:0]   c_ps, c_qc;
  logic signed [31:0]   c_x1, c_y1, c_z2, c_yp;
  logic        [17:0]   c_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_pc  <= b_p1 * view_cos;
    c_qs  <= b_p1 * view_sin;
    c_ps  <= $signed({1'b0, detector_offset}) * view_sin;
    c_qc  <= $signed({1'b0, detector_offset}) * view_cos;
    c_x1  <= b_x1;
    c_y1  <= b_y1;
    c_z2  <= b_z2;
    c_yp  <= b_yp;
    c_ray <= b_ray;
  end

  // --------------------------------------------------------------------------
  // Stage D: rotated cell position back in Q16.16.
  // --------------------------------------------------------------------------
  logic               d_vld;
  logic signed [31:0] d_x1, d_y1, d_x2, d_y2, d_z2, d_yp;
  logic        [17:0] d_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_x2  <= sat32((66'(c_pc) - 66'(c_ps)) >>> cbrvi_pkg::FRAC);
    d_y2  <= sat32((66'(c_qs) + 66'(c_qc)) >>> cbrvi_pkg::FRAC);
    d_x1  <= c_x1;
    d_y1  <= c_y1;
    d_z2  <= c_z2;
    d_yp  <= c_yp;
    d_ray <= c_ray;
  end

  // --------------------------------------------------------------------------
  // Stage E: ratio numerator and denominator. A ray parallel to the plane
  // has a zero denominator and is dropped here.
  // --------------------------------------------------------------------------
  logic               e_vld;
  logic signed [32:0] e_den;
  logic signed [48:0] e_num;
  logic signed [31:0] e_x1, e_x2, e_z2, e_yp;
  logic        [17:0] e_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld && (d_y2 != d_y1);
    end
  end

  always_ff @(posedge clk) begin
    e_den <= 33'(d_y2) - 33'(d_y1);
    e_num <= (49'(d_yp) - 49'(d_y1)) <<< cbrvi_pkg::FRAC;
    e_x1  <= d_x1;
    e_x2  <= d_x2;
    e_z2  <= d_z2;
    e_yp  <= d_yp;
    e_ray <= d_ray;
  end

  // --------------------------------------------------------------------------
  // Stage F: magnitudes for the unsigned divider; the sign goes alongside.
  // --------------------------------------------------------------------------
  logic                 f_vld;
  logic [48:0]          f_un;
  logic [32:0]          f_ud;
  cbrvi_pkg::ray_side_t f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    f_un        <= e_num[48] ? 49'(-e_num) : 49'(e_num);
    f_ud        <= e_den[32] ? 33'(-e_den) : 33'(e_den);
    f_side.neg  <= e_num[48] ^ e_den[32];
    f_side.x1   <= e_x1;
    f_side.x2   <= e_x2;
    f_side.z2   <= e_z2;
    f_side.yp   <= e_yp;
    f_side.ray  <= e_ray;
  end

  // Ratio division, one quotient bit per stage.
  logic                      r_vld;
  logic [0:0][cbrvi_pkg::R_QB-1:0] r_q;
  logic [0:0]                r_ovf, r_rnz;
  logic [SIDE_W-1:0]         r_side_bits;
  cbrvi_pkg::ray_side_t      r_side;

  cbrvi_div #(
    .NW    (49),
    .DW    (33),
    .QB    (cbrvi_pkg::R_QB),
    .LANES (1),
    .SW    (SIDE_W)
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_vld),
    .num       (f_un),
    .den       (f_ud),
    .side      (f_side),
    .out_valid (r_vld),
    .quo       (r_q),
    .ovf       (r_ovf),
    .rem_nz    (r_rnz),
    .out_side  (r_side_bits)
  );

  assign r_side = cbrvi_pkg::ray_side_t'(r_side_bits);

  // --------------------------------------------------------------------------
  // Stage G: floor rounding of a negative ratio, then the symmetric clamp.
  // The ray deltas are formed alongside.
  // --------------------------------------------------------------------------
  logic [31:0] r_mag, r_sat;
  assign r_mag = r_side.neg ? ({1'b0, r_q[0]} + 32'(r_rnz[0])) : {1'b0, r_q[0]};
  assign r_sat = (r_ovf[0] || (r_mag > cbrvi_pkg::R_MAX)) ? cbrvi_pkg::R_MAX : r_mag;

  logic               g_vld;
  logic signed [31:0] g_r, g_x1, g_yp;
  logic signed [32:0] g_dx, g_dz;
  logic        [17:0] g_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else begin
      g_vld <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    g_r   <= r_side.neg ? -$signed(r_sat) : $signed(r_sat);
    g_dx  <= 33'(r_side.x2) - 33'(r_side.x1);
    g_dz  <= 33'(r_side.z2) - 33'(source_z);
    g_x1  <= r_side.x1;
    g_yp  <= r_side.yp;
    g_ray <= r_side.ray;
  end

  // --------------------------------------------------------------------------
  // Stage H: scale the deltas by the ratio.
  // --------------------------------------------------------------------------
  logic               h_vld;
  logic signed [64:0] h_px, h_pz;
  logic signed [31:0] h_x1, h_yp;
  logic        [17:0] h_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    h_px  <= g_dx * g_r;
    h_pz  <= g_dz * g_r;
    h_x1  <= g_x1;
    h_yp  <= g_yp;
    h_ray <= g_ray;
  end

  // --------------------------------------------------------------------------
  // Stage I: hit point on the plane.
  // --------------------------------------------------------------------------
  logic               i_vld;
  logic signed [49:0] i_x, i_z;
  logic signed [31:0] i_yp;
  logic        [17:0] i_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else begin
      i_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    i_x   <= 50'(h_x1) + 50'(h_px >>> cbrvi_pkg::FRAC);
    i_z   <= 50'(source_z) + 50'(h_pz >>> cbrvi_pkg::FRAC);
    i_yp  <= h_yp;
    i_ray <= h_ray;
  end

  // --------------------------------------------------------------------------
  // Stage J: inside test against the cube. For a hit all three distances
  // from the cube faces lie in [0, 2h), so 32 unsigned bits hold them.
  // --------------------------------------------------------------------------
  logic in_cube;
  assign in_cube = (i_yp >= -hs) && (i_yp < hs) &&
                   (i_x > 50'(-hs)) && (i_x <= 50'(hs)) &&
                   (i_z > 50'(-hs)) && (i_z <= 50'(hs));

  logic                 j_vld;
  logic [2:0][31:0]     j_num;
  logic [17:0]          j_ray;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else begin
      j_vld <= i_vld && in_cube;
    end
  end

  always_ff @(posedge clk) begin
    j_num[0] <= 32'(52'(hs) - 52'(i_x));
    j_num[1] <= 32'(33'(i_yp) + 33'(hs));
    j_num[2] <= 32'(52'(hs) - 52'(i_z));
    j_ray    <= i_ray;
  end

  // Voxel coordinates: three lanes share the voxel pitch as divisor.
  logic               v_vld;
  logic [2:0][MW-1:0] v_q;
  logic [2:0]         v_ovf, v_rnz;
  logic [17:0]        v_ray;

  cbrvi_div #(
    .NW    (32),
    .DW    (31),
    .QB    (MW),
    .LANES (3),
    .SW    (18)
  ) u_voxel_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (j_vld),
    .num       (j_num),
    .den       (vp),
    .side      (j_ray),
    .out_valid (v_vld),
    .quo       (v_q),
    .ovf       (v_ovf),
    .rem_nz    (v_rnz),
    .out_side  (v_ray)
  );

  // --------------------------------------------------------------------------
  // Stage K: clamp each coordinate to the volume and form the address.
  // The remainders play no part in a truncating division.
  // --------------------------------------------------------------------------
  logic [MW-1:0] m1, m2, m3;
  logic [IW-1:0] idx_full;
  logic          unused_rnz;

  assign m1 = clamp_m(v_q[0], v_ovf[0]);
  assign m2 = clamp_m(v_q[1], v_ovf[1]);
  assign m3 = clamp_m(v_q[2], v_ovf[2]);
  assign idx_full = IW'(m1) * IW'(NPIX * NPIX) + IW'(m3) * IW'(NPIX) + IW'(m2);
  assign unused_rnz = |v_rnz;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_vld;
    end
  end

  always_ff @(posedge clk) begin
    result.voxel_index <= 27'(idx_full) | 27'(unused_rnz & 1'b0);
    result.ray_number  <= v_ray;
  end

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  `CBRVI_ASSERT_IMPLIES(a_done_has_item, done, $past(start, LATENCY), "beat without item")
  `CBRVI_ASSERT_IMPLIES(a_ratio_latency, r_vld, $past(f_vld, cbrvi_pkg::R_QB + 1), "ratio timing")
  `CBRVI_ASSERT_NEVER(a_ratio_symmetric, g_vld && (g_r == cbrvi_pkg::R_MIN), "ratio off clamp")

endmodule
